[sv/jsmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_pkg
// Shared types and constants of the joystick servo mode controller.
// ----------------------------------------------------------------------------
package jsmc_pkg;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_PID    = 2'd2,
    MODE_SHUT   = 2'd3
  } jsmc_mode_e;

  // command letters
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ANGLE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP   = 3'd1;
  localparam logic [2:0] REG_REPEAT_MS    = 3'd2;
  localparam logic [2:0] REG_RECENTER_MS  = 3'd3;
  localparam logic [2:0] REG_LINK_TIMEOUT = 3'd4;

  localparam logic [6:0]  RST_ANGLE_LIMIT  = 7'd70;
  localparam logic [4:0]  RST_ANGLE_STEP   = 5'd5;
  localparam logic [15:0] RST_REPEAT_MS    = 16'd75;
  localparam logic [15:0] RST_RECENTER_MS  = 16'd10;
  localparam logic [15:0] RST_LINK_TIMEOUT = 16'd100;

  localparam logic [6:0]  ANGLE_MAX  = 7'd90;
  localparam logic [7:0]  ANGLE_OFS  = 8'd90;
  localparam logic [15:0] AGE_MAX    = 16'hFFFF;

  // pulse = floor(u*100/9) + 500, u = angle + 90, via 100*ceil(2^20/9)
  localparam logic [31:0] PULSE_MUL  = 32'd11650900;
  localparam logic [11:0] PULSE_BASE = 12'd500;
  // duty = floor((idx*1024 + 13)/26) via ceil(2^20/26)
  localparam logic [31:0] DUTY_MUL   = 32'd40330;
  localparam logic [14:0] DUTY_RND   = 15'd13;
  localparam logic [10:0] DUTY_FULL  = 11'd1024;

  typedef struct packed {
    logic [6:0]  angle_limit;
    logic [4:0]  angle_step;
    logic [15:0] repeat_ms;
    logic [15:0] recenter_ms;
    logic [15:0] link_timeout_ms;
  } jsmc_cfg_t;

  typedef struct packed {
    logic       packet_arrived;
    logic [7:0] cmd_roll;
    logic [7:0] cmd_pitch;
    logic [7:0] cmd_throttle;
  } jsmc_item_t;

  typedef struct packed {
    jsmc_mode_e        mode;
    logic signed [7:0] x_angle;
    logic signed [7:0] y_angle;
    logic [7:0]        throttle;
  } jsmc_res_t;

  typedef struct packed {
    jsmc_mode_e  mode;
    logic [11:0] x_pulse_us;
    logic [11:0] y_pulse_us;
    logic [10:0] motor_duty;
    logic        autopilot_select;
    logic        shutdown_select;
  } jsmc_out_t;

endpackage

[sv/joystick_servo_mode_controller_core.sv]
`timescale 1ns / 1ps
// an input beat passes through the input register and then the result register to become a result beat
// throughput: one tick per cycle while the result side does not stall; the state update is combinational logic
// the input register frees whenever the result register can take its beat
// reset (async, active low): mode manual, angles and ages zero,
// stored command letters C, C, A, config registers at defaults
// ----------------------------------------------------------------------------
// joystick_servo_mode_controller_core
// Per-tick mode decode, link timeout, servo stepping and motor duty.
// ----------------------------------------------------------------------------
module joystick_servo_mode_controller_core import jsmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cmd_roll, cmd_pitch, cmd_throttle
  input  logic        s_axis_tuser,  // packet_arrived
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // x_pulse_us, y_pulse_us, motor_duty, zero pad
  output logic [3:0]  m_axis_tuser,  // mode, autopilot_select, shutdown_select
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  jsmc_cfg_t  cfg;
  jsmc_item_t in_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic       advance;
  jsmc_res_t  res;
  jsmc_out_t  out_d, out_q;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  jsmc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.packet_arrived <= s_axis_tuser;
      in_q.cmd_roll       <= s_axis_tdata[7:0];
      in_q.cmd_pitch      <= s_axis_tdata[15:8];
      in_q.cmd_throttle   <= s_axis_tdata[23:16];
    end
  end

  jsmc_tick_update u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (in_q),
    .advance_i (advance),
    .res_o     (res)
  );

  jsmc_out_map u_map (
    .res_i (res),
    .out_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.motor_duty, out_q.y_pulse_us, out_q.x_pulse_us};
  assign m_axis_tuser  = {out_q.shutdown_select, out_q.autopilot_select, out_q.mode};

endmodule

[sv/jsmc_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_apb_regs
// APB configuration registers: angle limit, step, repeat, recenter, timeout.
// ----------------------------------------------------------------------------
module jsmc_apb_regs import jsmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output jsmc_cfg_t   cfg_o
);

  jsmc_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_limit     <= RST_ANGLE_LIMIT;
      cfg_q.angle_step      <= RST_ANGLE_STEP;
      cfg_q.repeat_ms       <= RST_REPEAT_MS;
      cfg_q.recenter_ms     <= RST_RECENTER_MS;
      cfg_q.link_timeout_ms <= RST_LINK_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ANGLE_LIMIT:  cfg_q.angle_limit     <= pwdata[6:0];
        REG_ANGLE_STEP:   cfg_q.angle_step      <= pwdata[4:0];
        REG_REPEAT_MS:    cfg_q.repeat_ms       <= pwdata[15:0];
        REG_RECENTER_MS:  cfg_q.recenter_ms     <= pwdata[15:0];
        REG_LINK_TIMEOUT: cfg_q.link_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_LIMIT:  prdata = {25'd0, cfg_q.angle_limit};
      REG_ANGLE_STEP:   prdata = {27'd0, cfg_q.angle_step};
      REG_REPEAT_MS:    prdata = {16'd0, cfg_q.repeat_ms};
      REG_RECENTER_MS:  prdata = {16'd0, cfg_q.recenter_ms};
      REG_LINK_TIMEOUT: prdata = {16'd0, cfg_q.link_timeout_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

[sv/jsmc_tick_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_tick_update
// Controller state and its per-tick next-state logic: ages, mode, angles.
// ----------------------------------------------------------------------------
module jsmc_tick_update import jsmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jsmc_cfg_t  cfg_i,
  input  jsmc_item_t item_i,
  input  logic       advance_i,
  output jsmc_res_t  res_o
);

  typedef struct packed {
    logic signed [7:0] angle;
    logic [15:0]       rec;
    logic [15:0]       rep;
  } jsmc_axis_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] a);
    return (a == AGE_MAX) ? a : a + 16'd1;
  endfunction

  function automatic jsmc_axis_t axis_step(
    input logic signed [7:0] a,
    input logic [15:0]       rec,
    input logic [15:0]       rep,
    input logic              centred,
    input logic [7:0]        c,
    input jsmc_cfg_t         cfg,
    input logic [6:0]        lim
  );
    logic signed [8:0] a_w;
    logic signed [8:0] s_w;
    logic signed [8:0] l_w;
    jsmc_axis_t        r;
    a_w   = {a[7], a};
    s_w   = signed'({4'd0, cfg.angle_step});
    l_w   = signed'({2'd0, lim});
    r.rec = rec;
    r.rep = rep;
    if (centred) begin
      if (rec >= cfg.recenter_ms) begin
        // walk toward zero, never past it
        if (a_w > 9'sd0) begin
          a_w = (a_w > s_w) ? a_w - s_w : 9'sd0;
        end else if (a_w < 9'sd0) begin
          a_w = (-a_w > s_w) ? a_w + s_w : 9'sd0;
        end
        r.rec = '0;
      end
    end else if (c == CHAR_A || c == CHAR_B) begin
      r.rec = '0;
      if (rep >= cfg.repeat_ms) begin
        a_w   = (c == CHAR_A) ? a_w + s_w : a_w - s_w;
        r.rep = '0;
      end
    end
    if (a_w > l_w) begin
      a_w = l_w;
    end else if (a_w < -l_w) begin
      a_w = -l_w;
    end
    r.angle = a_w[7:0];
    return r;
  endfunction

  logic [7:0]        roll_q, pitch_q, thr_q;
  logic [7:0]        roll_d, pitch_d, thr_d;
  jsmc_mode_e        mode_q, mode_d;
  logic [15:0]       link_q, link_d;
  logic signed [7:0] x_q, y_q, x_d, y_d;
  logic [15:0]       rec_x_q, rec_y_q, rep_x_q, rep_y_q;
  logic [15:0]       rec_x_d, rec_y_d, rep_x_d, rep_y_d;
  logic [6:0]        lim;
  jsmc_axis_t        ax_x, ax_y;

  assign lim = (cfg_i.angle_limit > ANGLE_MAX) ? ANGLE_MAX : cfg_i.angle_limit;

  always_comb begin
    roll_d  = roll_q;
    pitch_d = pitch_q;
    thr_d   = thr_q;
    mode_d  = mode_q;
    x_d     = x_q;
    y_d     = y_q;
    link_d  = sat_inc(link_q);
    rec_x_d = sat_inc(rec_x_q);
    rec_y_d = sat_inc(rec_y_q);
    rep_x_d = sat_inc(rep_x_q);
    rep_y_d = sat_inc(rep_y_q);
    ax_x    = '0;
    ax_y    = '0;

    if (item_i.packet_arrived) begin
      roll_d  = item_i.cmd_roll;
      pitch_d = item_i.cmd_pitch;
      thr_d   = item_i.cmd_throttle;
      link_d  = '0;
      priority if (item_i.cmd_roll == CHAR_A || item_i.cmd_roll == CHAR_B ||
                   item_i.cmd_roll == CHAR_C) begin
        mode_d = MODE_MANUAL;
      end else if (item_i.cmd_roll == CHAR_D) begin
        mode_d = MODE_AUTO;
      end else if (item_i.cmd_roll == CHAR_E) begin
        mode_d = MODE_PID;
      end else if (item_i.cmd_roll == CHAR_F) begin
        mode_d = MODE_SHUT;
      end else begin
        // any other letter keeps the mode
        mode_d = mode_q;
      end
    end

    // link loss only drops manual
    if (link_d >= cfg_i.link_timeout_ms && mode_d == MODE_MANUAL) begin
      mode_d = MODE_AUTO;
    end

    if (mode_d == MODE_MANUAL) begin
      if (mode_q != MODE_MANUAL) begin
        rep_x_d = '0;
        rep_y_d = '0;
        rec_x_d = '0;
      end
      ax_x = axis_step(x_q, rec_x_d, rep_x_d, roll_d == CHAR_C && pitch_d == CHAR_C,
                       roll_d, cfg_i, lim);
      ax_y = axis_step(y_q, rec_y_d, rep_y_d, pitch_d == CHAR_C, pitch_d, cfg_i, lim);
      x_d     = ax_x.angle;
      rec_x_d = ax_x.rec;
      rep_x_d = ax_x.rep;
      y_d     = ax_y.angle;
      rec_y_d = ax_y.rec;
      rep_y_d = ax_y.rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= CHAR_C;
      pitch_q <= CHAR_C;
      thr_q   <= CHAR_A;
      mode_q  <= MODE_MANUAL;
      link_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      rec_x_q <= '0;
      rec_y_q <= '0;
      rep_x_q <= '0;
      rep_y_q <= '0;
    end else if (advance_i) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      thr_q   <= thr_d;
      mode_q  <= mode_d;
      link_q  <= link_d;
      x_q     <= x_d;
      y_q     <= y_d;
      rec_x_q <= rec_x_d;
      rec_y_q <= rec_y_d;
      rep_x_q <= rep_x_d;
      rep_y_q <= rep_y_d;
    end
  end

  assign res_o.mode     = mode_d;
  assign res_o.x_angle  = x_d;
  assign res_o.y_angle  = y_d;
  assign res_o.throttle = thr_d;

endmodule

[sv/jsmc_out_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_out_map
// Maps angles to servo pulse widths and, in manual mode, the throttle letter to motor duty.
// ----------------------------------------------------------------------------
module jsmc_out_map import jsmc_pkg::*; (
  input  jsmc_res_t res_i,
  output jsmc_out_t out_o
);

  function automatic logic [11:0] pulse(input logic signed [7:0] a);
    logic [7:0]  u;
    logic [31:0] p;
    u = a[7:0] + ANGLE_OFS;
    p = {24'd0, u} * PULSE_MUL;
    return {1'b0, p[30:20]} + PULSE_BASE;
  endfunction

  function automatic logic [10:0] duty(input logic [7:0] t);
    logic [4:0]  idx;
    logic [14:0] w;
    logic [31:0] p;
    idx = 5'(t - CHAR_A) + 5'd1;
    w   = {idx, 10'd0} + DUTY_RND;
    p   = {17'd0, w} * DUTY_MUL;
    if (t <= CHAR_A) begin
      return 11'd0;
    end else if (t > CHAR_Z) begin
      return DUTY_FULL;
    end
    return p[30:20];
  endfunction

  always_comb begin
    out_o.mode             = res_i.mode;
    out_o.x_pulse_us       = pulse(res_i.x_angle);
    out_o.y_pulse_us       = pulse(res_i.y_angle);
    out_o.motor_duty       = (res_i.mode == MODE_MANUAL) ? duty(res_i.throttle) : 11'd0;
    out_o.autopilot_select = (res_i.mode == MODE_AUTO);
    out_o.shutdown_select  = (res_i.mode == MODE_SHUT);
  end

endmodule

[sv/jsmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_sva
// Port-level checks on result beats of the mode controller.
// ----------------------------------------------------------------------------
module jsmc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);

  // select flags agree with the mode code
  a_sel_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[1:0] == 2'd1)) &&
                      (m_axis_tuser[3] == (m_axis_tuser[1:0] == 2'd3)))
    else $error("select flags disagree with mode");

  // motor runs only in manual, never above full scale
  a_duty_manual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[34:24] <= 11'd1024) &&
                      ((m_axis_tdata[34:24] == 11'd0) || (m_axis_tuser[1:0] == 2'd0)))
    else $error("motor duty outside manual or above full scale");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:0] >= 12'd500) && (m_axis_tdata[11:0] <= 12'd2500) &&
                      (m_axis_tdata[23:12] >= 12'd500) && (m_axis_tdata[23:12] <= 12'd2500))
    else $error("servo pulse out of range");

  // a result beat leaving always frees room for a new input beat
  a_ready_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

endmodule

bind joystick_servo_mode_controller_core jsmc_sva u_jsmc_sva (.*);

[dv/jsmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsmc_checker
// Watches the tick stream, the result stream and the register port of the
// joystick servo mode controller. It keeps its own copy of the controller
// state, predicts the result of every accepted tick and compares each
// result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module jsmc_checker import jsmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // cmd_roll, cmd_pitch, cmd_throttle
  input  logic        s_tuser_i,   // packet_arrived
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // x_pulse_us, y_pulse_us, motor_duty, zero pad
  input  logic [3:0]  m_tuser_i,   // mode, autopilot_select, shutdown_select
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          errors_o,
  output int          pending_o
);

  jsmc_cfg_t   cfg;
  logic [7:0]  stored_cmd [3];
  jsmc_mode_e  mode_q;
  logic [15:0] link_age;
  logic [15:0] rc_age [2];
  logic [15:0] rp_age [2];
  int          x_ang;
  int          y_ang;

  jsmc_out_t   expected_q [$];
  jsmc_out_t   got;
  jsmc_out_t   want;
  jsmc_out_t   predicted;
  int          err_count;

  assign errors_o = err_count;

  function automatic logic [15:0] age_up(input logic [15:0] a);
    return (a == AGE_MAX) ? a : a + 16'd1;
  endfunction

  function automatic logic [11:0] servo_pulse(input int a);
    int v;
    v = (a + 90) * 2000 / 180 + 500;
    return v[11:0];
  endfunction

  task automatic step_axis(inout int ang, input int idx, input logic centred,
                           input logic [7:0] c);
    int s;
    s = int'(cfg.angle_step);
    if (centred) begin
      if (rc_age[idx] >= cfg.recenter_ms) begin
        if (ang > s) ang -= s;
        else if (ang < -s) ang += s;
        else ang = 0;
        rc_age[idx] = '0;
      end
    end else if (c == CHAR_A || c == CHAR_B) begin
      rc_age[idx] = '0;
      if (rp_age[idx] >= cfg.repeat_ms) begin
        ang = (c == CHAR_A) ? ang + s : ang - s;
        rp_age[idx] = '0;
      end
    end
  endtask

  task automatic advance_tick(input logic pkt, input logic [7:0] roll,
                              input logic [7:0] pitch, input logic [7:0] thr,
                              output jsmc_out_t res);
    jsmc_mode_e prev;
    int         lim;
    int         idx;
    prev = mode_q;
    link_age = age_up(link_age);
    for (int i = 0; i < 2; i++) begin
      rc_age[i] = age_up(rc_age[i]);
      rp_age[i] = age_up(rp_age[i]);
    end
    if (pkt) begin
      stored_cmd[0] = roll;
      stored_cmd[1] = pitch;
      stored_cmd[2] = thr;
      link_age = '0;
      case (roll)
        CHAR_A, CHAR_B, CHAR_C: mode_q = MODE_MANUAL;
        CHAR_D: mode_q = MODE_AUTO;
        CHAR_E: mode_q = MODE_PID;
        CHAR_F: mode_q = MODE_SHUT;
        default: ;
      endcase
    end
    if (link_age >= cfg.link_timeout_ms && mode_q == MODE_MANUAL) mode_q = MODE_AUTO;
    if (mode_q == MODE_MANUAL) begin
      // coming back into manual restarts both repeat timers and the x recentre timer
      if (prev != MODE_MANUAL) begin
        rp_age[0] = '0;
        rp_age[1] = '0;
        rc_age[0] = '0;
      end
      step_axis(x_ang, 0, stored_cmd[0] == CHAR_C && stored_cmd[1] == CHAR_C,
                stored_cmd[0]);
      step_axis(y_ang, 1, stored_cmd[1] == CHAR_C, stored_cmd[1]);
      lim = (cfg.angle_limit > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(cfg.angle_limit);
      if (x_ang > lim) x_ang = lim;
      else if (x_ang < -lim) x_ang = -lim;
      if (y_ang > lim) y_ang = lim;
      else if (y_ang < -lim) y_ang = -lim;
    end
    res.mode       = mode_q;
    res.x_pulse_us = servo_pulse(x_ang);
    res.y_pulse_us = servo_pulse(y_ang);
    if (mode_q != MODE_MANUAL || stored_cmd[2] <= CHAR_A) begin
      res.motor_duty = '0;
    end else if (stored_cmd[2] > CHAR_Z) begin
      res.motor_duty = DUTY_FULL;
    end else begin
      idx = int'(stored_cmd[2]) - int'(CHAR_A) + 1;
      res.motor_duty = 11'((idx * 1024 + 13) / 26);
    end
    res.autopilot_select = (mode_q == MODE_AUTO);
    res.shutdown_select  = (mode_q == MODE_SHUT);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.angle_limit     = RST_ANGLE_LIMIT;
      cfg.angle_step      = RST_ANGLE_STEP;
      cfg.repeat_ms       = RST_REPEAT_MS;
      cfg.recenter_ms     = RST_RECENTER_MS;
      cfg.link_timeout_ms = RST_LINK_TIMEOUT;
      stored_cmd[0] = CHAR_C;
      stored_cmd[1] = CHAR_C;
      stored_cmd[2] = CHAR_A;
      mode_q   = MODE_MANUAL;
      link_age = '0;
      rc_age[0] = '0;
      rc_age[1] = '0;
      rp_age[0] = '0;
      rp_age[1] = '0;
      x_ang = 0;
      y_ang = 0;
      err_count = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.mode             = jsmc_mode_e'(m_tuser_i[1:0]);
        got.autopilot_select = m_tuser_i[2];
        got.shutdown_select  = m_tuser_i[3];
        got.x_pulse_us       = m_tdata_i[11:0];
        got.y_pulse_us       = m_tdata_i[23:12];
        got.motor_duty       = m_tdata_i[34:24];
        if (expected_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result beat with nothing outstanding", $time);
        end else begin
          want = expected_q.pop_front();
          if (got.mode !== want.mode || got.x_pulse_us !== want.x_pulse_us ||
              got.y_pulse_us !== want.y_pulse_us ||
              got.motor_duty !== want.motor_duty ||
              got.autopilot_select !== want.autopilot_select ||
              got.shutdown_select !== want.shutdown_select) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%0t: expected mode %0d x %0d y %0d duty %0d auto %0b shut %0b",
                       $time, want.mode, want.x_pulse_us, want.y_pulse_us,
                       want.motor_duty, want.autopilot_select, want.shutdown_select);
              $display("%0t:      got mode %0d x %0d y %0d duty %0d auto %0b shut %0b",
                       $time, got.mode, got.x_pulse_us, got.y_pulse_us,
                       got.motor_duty, got.autopilot_select, got.shutdown_select);
            end
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_ANGLE_LIMIT:  cfg.angle_limit     = pwdata_i[6:0];
          REG_ANGLE_STEP:   cfg.angle_step      = pwdata_i[4:0];
          REG_REPEAT_MS:    cfg.repeat_ms       = pwdata_i[15:0];
          REG_RECENTER_MS:  cfg.recenter_ms     = pwdata_i[15:0];
          REG_LINK_TIMEOUT: cfg.link_timeout_ms = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_tick(s_tuser_i, s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[23:16],
                     predicted);
        expected_q.push_back(predicted);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the joystick servo mode controller: directed ticks covering
// every mode letter, throttle edges, stepping, recentring and link timeout,
// then random command streams under a range of register settings and
// handshake idling patterns. Checking is done by jsmc_checker.
// ----------------------------------------------------------------------------
module tb import jsmc_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // cmd_roll, cmd_pitch, cmd_throttle
  logic        s_axis_tuser;   // packet_arrived
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // x_pulse_us, y_pulse_us, motor_duty, zero pad
  logic [3:0]  m_axis_tuser;   // mode, autopilot_select, shutdown_select
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int chk_errors;
  int chk_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int pkt_pct = 40;

  joystick_servo_mode_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  jsmc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .errors_o   (chk_errors),
    .pending_o  (chk_pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // one tick beat, held until accepted; called at a falling edge
  task automatic send_tick(input logic pkt, input logic [7:0] roll,
                           input logic [7:0] pitch, input logic [7:0] thr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = pkt;
    s_axis_tdata  = {thr, pitch, roll};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic rand_tick();
    logic       pkt;
    logic [7:0] roll;
    logic [7:0] pitch;
    logic [7:0] thr;
    int         r;
    pkt = ($urandom_range(99) < pkt_pct);
    r = $urandom_range(99);
    if (!pkt || r >= 70) roll = 8'($urandom_range(255));
    else if (r < 55) roll = CHAR_A + 8'($urandom_range(2));
    else roll = CHAR_D + 8'($urandom_range(2));
    if (!pkt || $urandom_range(99) >= 80) pitch = 8'($urandom_range(255));
    else pitch = CHAR_A + 8'($urandom_range(2));
    r = $urandom_range(99);
    if (!pkt || r >= 80) begin
      thr = 8'($urandom_range(255));
    end else if (r < 70) begin
      thr = CHAR_A + 8'($urandom_range(25));
    end else begin
      case ($urandom_range(3))
        0: thr = 8'h00;
        1: thr = CHAR_A - 8'd1;
        2: thr = CHAR_Z + 8'd1;
        default: thr = 8'hFF;
      endcase
    end
    send_tick(pkt, roll, pitch, thr);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (chk_pending != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_cfg(input int lim, input int step, input int rep,
                           input int rec, input int tmo);
    drain();
    write_reg(REG_ANGLE_LIMIT, 32'(lim));
    write_reg(REG_ANGLE_STEP, 32'(step));
    write_reg(REG_REPEAT_MS, 32'(rep));
    write_reg(REG_RECENTER_MS, 32'(rec));
    write_reg(REG_LINK_TIMEOUT, 32'(tmo));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: throttle edges and every mode letter
    send_tick(1'b1, CHAR_C, CHAR_C, 8'h00);
    send_tick(1'b1, CHAR_C, CHAR_C, CHAR_A);
    send_tick(1'b1, CHAR_A, CHAR_C, CHAR_B);
    send_tick(1'b1, CHAR_B, CHAR_A, CHAR_Z);
    send_tick(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_tick(1'b1, "G", CHAR_B, CHAR_Z + 8'd1);
    send_tick(1'b1, CHAR_C, CHAR_C, 8'hFF);
    send_tick(1'b1, 8'h00, 8'h00, CHAR_A - 8'd1);
    send_tick(1'b1, CHAR_D, CHAR_C, "M");
    send_tick(1'b1, CHAR_E, CHAR_C, "M");
    send_tick(1'b1, CHAR_F, CHAR_C, "M");
    send_tick(1'b1, CHAR_C, "X", "M");

    // fast stepping: limit above ninety, recentre overshoot, short timeout
    apply_cfg(127, 31, 1, 1, 4);
    repeat (4) send_tick(1'b1, CHAR_A, CHAR_A, CHAR_Z);
    repeat (3) send_tick(1'b1, CHAR_C, CHAR_C, CHAR_A);
    repeat (2) send_tick(1'b1, CHAR_B, "Q", "N");
    repeat (5) send_tick(1'b0, 8'h00, 8'h00, 8'h00);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_cfg(90, 31, 1, 1, 20);
        1: apply_cfg(127, 7, 2, 3, 65535);
        2: apply_cfg(0, 5, 1, 2, 10);
        3: apply_cfg($urandom_range(127), $urandom_range(31), $urandom_range(6),
                     $urandom_range(6), $urandom_range(40, 1));
        4: apply_cfg(45, 0, 0, 0, 0);
        5: apply_cfg(127, 31, 65535, 65535, 8);
        6: apply_cfg($urandom_range(127), $urandom_range(31), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(65535));
        default: apply_cfg(1, 1, 3, 1, 15);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      pkt_pct = $urandom_range(60, 10);
      for (int n = 0; n < 200; n++) begin
        // stretches without idling inside every phase
        if (n == 100) begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        rand_tick();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[joystick_servo_mode_controller_core.f]
sv/jsmc_pkg.sv
sv/jsmc_apb_regs.sv
sv/jsmc_tick_update.sv
sv/jsmc_out_map.sv
sv/joystick_servo_mode_controller_core.sv
sv/jsmc_checker.sv
dv/jsmc_checker.sv
dv/tb.sv
